### hdl/cleb_pkg.sv
package cleb_pkg;

    // Default ring size
    localparam int RING_DEPTH_DEF = 128;

    // Field widths of the beats on both channels
    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 3;
    localparam int COUNT_W = 8;

    // Keystroke codes
    localparam logic [CHAR_W-1:0] KEY_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] KEY_EOF  = 8'h04;
    localparam logic [CHAR_W-1:0] KEY_BS   = 8'h08;
    localparam logic [CHAR_W-1:0] KEY_LF   = 8'h0a;
    localparam logic [CHAR_W-1:0] KEY_CR   = 8'h0d;
    localparam logic [CHAR_W-1:0] KEY_DUMP = 8'h10;
    localparam logic [CHAR_W-1:0] KEY_KILL = 8'h15;
    localparam logic [CHAR_W-1:0] KEY_DEL  = 8'h7f;

    // Operation codes
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_NONE     = 3'd0,
        KIND_ECHO     = 3'd1,
        KIND_ECHO_EOF = 3'd2,
        KIND_ERASE    = 3'd3,
        KIND_DATA     = 3'd4,
        KIND_EMPTY    = 3'd5,
        KIND_EOF      = 3'd6
    } kind_t;

endpackage

### hdl/cleb_ifs.sv
// Request channel: one keystroke or one read per beat
interface cleb_req_if;
    import cleb_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [CHAR_W-1:0] key_char;
    logic              first_of_read;

    modport source (output valid, output operation, output key_char,
                    output first_of_read, input ready);
    modport sink   (input valid, input operation, input key_char,
                    input first_of_read, output ready);
endinterface

// Response channel: one result per request beat
interface cleb_rsp_if;
    import cleb_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  char_value;
    logic [COUNT_W-1:0] erase_count;
    logic               line_ready;
    logic               end_of_line;

    modport source (output valid, output kind, output char_value, output erase_count,
                    output line_ready, output end_of_line, input ready);
    modport sink   (input valid, input kind, input char_value, input erase_count,
                    input line_ready, input end_of_line, output ready);
endinterface

### hdl/console_line_edit_buffer.sv
// Cooked-mode console input ring. Each request beat is a keystroke or a single-character
// read and yields exactly one response beat. The first step of an item takes the
// beat and reads the ring memory at the read pointer, the second edits or pops, writes the
// keystroke back into the ring, moves the pointers and loads the response register. The
// response register holds while the sink stalls and the next request is still taken; a
// second finished item waits for the register to drain. The ring memory needs no clearing
// after reset: only committed entries, which were written, are ever read.
module console_line_edit_buffer #(
    parameter int RING_DEPTH = cleb_pkg::RING_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cleb_req_if.sink    req,
    cleb_rsp_if.source  rsp
);
    import cleb_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [CHAR_W-1:0] rd_data;

    cleb_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cleb_ring_mem #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW)
    ) u_ring_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

### hdl/cleb_ring_mem.sv
module cleb_ring_mem #(
    parameter int RING_DEPTH = cleb_pkg::RING_DEPTH_DEF,
    parameter int AW         = $clog2(RING_DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [cleb_pkg::CHAR_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [cleb_pkg::CHAR_W-1:0] rd_data
);
    import cleb_pkg::*;

    logic [CHAR_W-1:0] store_mem [RING_DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    // Write one character into the ring
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/cleb_ctrl.sv
module cleb_ctrl #(
    parameter int RING_DEPTH = cleb_pkg::RING_DEPTH_DEF,
    parameter int AW         = $clog2(RING_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    cleb_req_if.sink                    req,
    cleb_rsp_if.source                  rsp,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic [cleb_pkg::CHAR_W-1:0] wr_data,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    input  logic [cleb_pkg::CHAR_W-1:0] rd_data
);
    import cleb_pkg::*;

    // Pointers count modulo twice the depth so a full ring differs from an empty one
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] DEPTH_P   = PW'(RING_DEPTH);
    localparam logic [PW-1:0] SPAN_M1_P = PW'(2 * RING_DEPTH - 1);
    localparam logic [PW:0]   SPAN_X    = (PW + 1)'(2 * RING_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK
    } state_t;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == SPAN_M1_P) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? SPAN_M1_P : p - PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_diff(input logic [PW-1:0] a,
                                               input logic [PW-1:0] b);
        logic [PW:0] s;
        if (a >= b)
        begin
            s = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            s = {1'b0, a} + SPAN_X - {1'b0, b};
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [AW-1:0] slot(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = (p >= DEPTH_P) ? p - DEPTH_P : p;
        return s[AW-1:0];
    endfunction

    state_t             state_reg, state_next;
    logic [PW-1:0]      read_ptr_reg, read_ptr_next;
    logic [PW-1:0]      commit_ptr_reg, commit_ptr_next;
    logic [PW-1:0]      edit_ptr_reg, edit_ptr_next;
    logic               op_reg;
    logic [CHAR_W-1:0]  key_reg;
    logic               first_reg;

    logic               out_valid_reg, out_valid_next;
    kind_t              kind_reg, kind_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               line_ready_reg, line_ready_next;
    logic               eol_reg, eol_next;

    logic               accept;
    logic               fire;
    logic [PW-1:0]      span_used;
    logic [PW-1:0]      kill_count;
    logic [PW-1:0]      edit_inc;
    logic [CHAR_W-1:0]  stored_char;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign fire      = (state_reg == S_WORK) && (!out_valid_reg || rsp.ready);

    // Fetch the character at the read pointer as the beat is taken
    assign rd_en   = accept;
    assign rd_addr = slot(read_ptr_reg);

    assign span_used   = ptr_diff(edit_ptr_reg, read_ptr_reg);
    assign kill_count  = ptr_diff(edit_ptr_reg, commit_ptr_reg);
    assign edit_inc    = ptr_inc(edit_ptr_reg);
    assign stored_char = (key_reg == KEY_CR) ? KEY_LF : key_reg;

    assign wr_addr = slot(edit_ptr_reg);
    assign wr_data = stored_char;

    // Edit the line or pop a character, and form the result
    always_comb
    begin
        kind_next       = KIND_NONE;
        char_next       = '0;
        count_next      = '0;
        line_ready_next = 1'b0;
        eol_next        = 1'b0;
        read_ptr_next   = read_ptr_reg;
        commit_ptr_next = commit_ptr_reg;
        edit_ptr_next   = edit_ptr_reg;
        wr_en           = 1'b0;

        if (op_reg == OP_KEY)
        begin
            case (key_reg)
                KEY_DUMP:
                begin
                    kind_next = KIND_NONE;
                end
                KEY_KILL:
                begin
                    if (kill_count != '0)
                    begin
                        kind_next     = KIND_ERASE;
                        count_next    = COUNT_W'(kill_count);
                        edit_ptr_next = commit_ptr_reg;
                    end
                end
                KEY_BS, KEY_DEL:
                begin
                    if (edit_ptr_reg != commit_ptr_reg)
                    begin
                        kind_next     = KIND_ERASE;
                        count_next    = COUNT_W'(1);
                        edit_ptr_next = ptr_dec(edit_ptr_reg);
                    end
                end
                default:
                begin
                    if (key_reg != KEY_NUL && key_reg != KEY_LF && span_used < DEPTH_P)
                    begin
                        wr_en         = fire;
                        edit_ptr_next = edit_inc;
                        kind_next     = (stored_char == KEY_EOF) ? KIND_ECHO_EOF : KIND_ECHO;
                        char_next     = stored_char;
                        if (stored_char == KEY_LF || stored_char == KEY_EOF ||
                            ptr_diff(edit_inc, read_ptr_reg) == DEPTH_P)
                        begin
                            commit_ptr_next = edit_inc;
                            line_ready_next = 1'b1;
                        end
                    end
                end
            endcase
        end
        else
        begin
            if (read_ptr_reg == commit_ptr_reg)
            begin
                kind_next = KIND_EMPTY;
            end
            else if (rd_data == KEY_EOF)
            begin
                // Leave a Ctrl-D in place unless the read has just begun
                kind_next = KIND_EOF;
                if (first_reg)
                begin
                    read_ptr_next = ptr_inc(read_ptr_reg);
                end
            end
            else
            begin
                kind_next     = KIND_DATA;
                char_next     = rd_data;
                eol_next      = (rd_data == KEY_LF);
                read_ptr_next = ptr_inc(read_ptr_reg);
            end
        end
    end

    // Sequence the two steps of each beat
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                if (fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, pointers, the accepted beat and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            read_ptr_reg   <= '0;
            commit_ptr_reg <= '0;
            edit_ptr_reg   <= '0;
            op_reg         <= OP_KEY;
            key_reg        <= '0;
            first_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= KIND_NONE;
            char_reg       <= '0;
            count_reg      <= '0;
            line_ready_reg <= 1'b0;
            eol_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                op_reg    <= req.operation;
                key_reg   <= req.key_char;
                first_reg <= req.first_of_read;
            end
            if (fire)
            begin
                read_ptr_reg   <= read_ptr_next;
                commit_ptr_reg <= commit_ptr_next;
                edit_ptr_reg   <= edit_ptr_next;
                kind_reg       <= kind_next;
                char_reg       <= char_next;
                count_reg      <= count_next;
                line_ready_reg <= line_ready_next;
                eol_reg        <= eol_next;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = kind_reg;
    assign rsp.char_value  = char_reg;
    assign rsp.erase_count = count_reg;
    assign rsp.line_ready  = line_ready_reg;
    assign rsp.end_of_line = eol_reg;

endmodule
